>>> rtl/core/vfb_pkg.sv
// Shared constants, codes, request structs and pointer helpers for the flit buffer.
package vfb_pkg;

  localparam int DEPTH   = 16;
  localparam int FLIT_W  = 64;
  localparam int TIME_W  = 32;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DELAY_W = 8;
  localparam int DIU_W   = 5;
  localparam int CFG_W   = 8;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 3'd0,
    CMD_ENQUEUE     = 3'd1,
    CMD_DEQUEUE     = 3'd2,
    CMD_TAKE_CREDIT = 3'd3,
    CMD_CLEAR       = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_RET_DELAY    = 1'b0,
    REG_DEPTH_IN_USE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD_LOAD,
    S_RET_CHECK,
    S_RET_WAIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [FLIT_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } flit_mem_req_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [TIME_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } ret_mem_req_t;

  function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // (p + n) mod DEPTH, with p < DEPTH and n < DEPTH
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                              input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(DEPTH)) s = s - (CNT_W+1)'(DEPTH);
    return PTR_W'(s);
  endfunction

  // zero acts as one, anything above DEPTH as DEPTH
  function automatic logic [CNT_W-1:0] eff_depth(input logic [DIU_W-1:0] diu);
    logic [DIU_W+CNT_W-1:0] wide;
    wide = (DIU_W+CNT_W)'(diu);
    if (diu == '0) return CNT_W'(1);
    if (wide > (DIU_W+CNT_W)'(DEPTH)) return CNT_W'(DEPTH);
    return CNT_W'(diu);
  endfunction

endpackage

>>> rtl/core/vfb_ifs.sv
// Command and result channel interfaces of the flit buffer.
interface vfb_cmd_if import vfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [FLIT_W-1:0] flit_data;

  modport source (output valid, output cmd, output flit_data, input ready);
  modport sink   (input valid, input cmd, input flit_data, output ready);
endinterface

interface vfb_res_if import vfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FLIT_W-1:0] out_flit;
  logic [FLIT_W-1:0] head_flit;
  logic [FLIT_W-1:0] tail_flit;
  logic [OCC_W-1:0]  occupancy;
  logic              full_res;
  logic [STAT_W-1:0] status;

  modport source (output valid, output out_flit, output head_flit, output tail_flit,
                  output occupancy, output full_res, output status, input ready);
  modport sink   (input valid, input out_flit, input head_flit, input tail_flit,
                  input occupancy, input full_res, input status, output ready);
endinterface

>>> rtl/core/vc_flit_buffer_delayed_credits.sv
// Top level of the virtual-channel flit buffer with delayed credit return.
//
//   channel   dir   handshake          carries
//   cmd_ch    in    valid/ready        cmd, flit_data
//   res_ch    out   valid/ready        out_flit, head_flit, tail_flit, occupancy,
//                                      full_res, status
//   wr_*      in    wr_en only         wr_index, wr_data (return delay, depth in use)
//
// An item runs S_IDLE, then S_HEAD_LOAD for a dequeue that leaves flits behind (flit
// RAM read of the new head), then S_RET_CHECK, with a trip through S_RET_WAIT for each
// due credit popped from the return-time RAM (none for the pop that empties it).
// Reset: synchronous, no RAM clearing pass; ready low in reset, high again as soon
// as rst falls.
// The result sits in an output register; the next word is taken while it waits,
// and the sequencer only stalls at the end of an item if that register is still full.
module vc_flit_buffer_delayed_credits import vfb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  vfb_cmd_if.sink           cmd_ch,
  vfb_res_if.source         res_ch,
  input  logic              wr_en,
  input  logic [0:0]        wr_index,
  input  logic [CFG_W-1:0]  wr_data
);

  flit_mem_req_t     flit_req;
  ret_mem_req_t      ret_req;
  logic [FLIT_W-1:0] flit_rdata;
  logic [TIME_W-1:0] ret_rdata;

  vfb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_ch.valid),
    .cmd_ready     (cmd_ch.ready),
    .cmd           (cmd_ch.cmd),
    .flit_data     (cmd_ch.flit_data),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .res_out_flit  (res_ch.out_flit),
    .res_head_flit (res_ch.head_flit),
    .res_tail_flit (res_ch.tail_flit),
    .res_occupancy (res_ch.occupancy),
    .res_full      (res_ch.full_res),
    .res_status    (res_ch.status),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .flit_req      (flit_req),
    .flit_rdata    (flit_rdata),
    .ret_req       (ret_req),
    .ret_rdata     (ret_rdata)
  );

  vfb_ram #(.WIDTH(FLIT_W), .DEPTH(DEPTH)) u_flit_ram (
    .clk   (clk),
    .we    (flit_req.we),
    .waddr (flit_req.waddr),
    .wdata (flit_req.wdata),
    .raddr (flit_req.raddr),
    .rdata (flit_rdata)
  );

  vfb_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_ret_ram (
    .clk   (clk),
    .we    (ret_req.we),
    .waddr (ret_req.waddr),
    .wdata (ret_req.wdata),
    .raddr (ret_req.raddr),
    .rdata (ret_rdata)
  );

endmodule

>>> rtl/core/vfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/vfb_ctrl.sv
// Sequencer, pointers, credit counters and result register of the flit buffer.
module vfb_ctrl import vfb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // command side
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [FLIT_W-1:0]   flit_data,
  // result side
  output logic                res_valid,
  input  logic                res_ready,
  output logic [FLIT_W-1:0]   res_out_flit,
  output logic [FLIT_W-1:0]   res_head_flit,
  output logic [FLIT_W-1:0]   res_tail_flit,
  output logic [OCC_W-1:0]    res_occupancy,
  output logic                res_full,
  output logic [STAT_W-1:0]   res_status,
  // register writes
  input  logic                wr_en,
  input  logic [0:0]          wr_index,
  input  logic [CFG_W-1:0]    wr_data,
  // memories
  output flit_mem_req_t       flit_req,
  input  logic [FLIT_W-1:0]   flit_rdata,
  output ret_mem_req_t        ret_req,
  input  logic [TIME_W-1:0]   ret_rdata
);

  state_t             state, state_next;
  logic [PTR_W-1:0]   head_ptr, head_ptr_next;
  logic [PTR_W-1:0]   tail_ptr, tail_ptr_next;
  logic [CNT_W-1:0]   flit_count, flit_count_next;
  logic [CNT_W-1:0]   used_credits, used_credits_next;
  logic [TIME_W-1:0]  cur_time, cur_time_next;
  logic [PTR_W-1:0]   ret_head, ret_head_next;
  logic [CNT_W-1:0]   ret_count, ret_count_next;
  logic [DELAY_W-1:0] ret_delay;
  logic [DIU_W-1:0]   depth_in_use;
  logic               res_valid_next;

  // cached copies of the head/tail words and of the oldest return time
  logic [FLIT_W-1:0]  head_flit, head_flit_next;
  logic [FLIT_W-1:0]  tail_flit, tail_flit_next;
  logic [TIME_W-1:0]  ret_head_time, ret_head_time_next;
  logic [FLIT_W-1:0]  op_flit, op_flit_next;
  status_t            op_status, op_status_next;
  logic               res_load;

  logic [CNT_W-1:0]   eff;
  logic [TIME_W-1:0]  due_diff;
  logic               ret_due;
  logic [TIME_W-1:0]  ret_time_new;

  assign eff          = eff_depth(depth_in_use);
  assign due_diff     = cur_time - ret_head_time;
  assign ret_due      = (ret_count != '0) && !due_diff[TIME_W-1];
  assign ret_time_new = cur_time + TIME_W'(ret_delay);
  assign cmd_ready    = (state == S_IDLE) && !rst;

  always_comb begin
    state_next         = state;
    head_ptr_next      = head_ptr;
    tail_ptr_next      = tail_ptr;
    flit_count_next    = flit_count;
    used_credits_next  = used_credits;
    cur_time_next      = cur_time;
    ret_head_next      = ret_head;
    ret_count_next     = ret_count;
    head_flit_next     = head_flit;
    tail_flit_next     = tail_flit;
    ret_head_time_next = ret_head_time;
    op_flit_next       = op_flit;
    op_status_next     = op_status;
    res_valid_next     = res_valid && !res_ready;
    res_load           = 1'b0;
    flit_req           = '0;
    ret_req            = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          op_flit_next   = '0;
          op_status_next = ST_OK;
          state_next     = S_RET_CHECK;
          unique case (cmd_t'(cmd))
            CMD_TICK: cur_time_next = cur_time + 1'b1;
            CMD_ENQUEUE: begin
              if (flit_count >= eff) begin
                op_status_next = ST_FULL;
              end else begin
                flit_req.we     = 1'b1;
                flit_req.waddr  = tail_ptr;
                flit_req.wdata  = flit_data;
                tail_ptr_next   = ptr_wrap(tail_ptr);
                flit_count_next = flit_count + 1'b1;
                tail_flit_next  = flit_data;
                if (flit_count == '0) head_flit_next = flit_data;
              end
            end
            CMD_DEQUEUE: begin
              if (flit_count == '0) begin
                op_status_next = ST_EMPTY;
              end else begin
                op_flit_next    = head_flit;
                head_ptr_next   = ptr_wrap(head_ptr);
                flit_count_next = flit_count - 1'b1;
                // fetch the new head word unless the buffer drains
                flit_req.raddr  = ptr_wrap(head_ptr);
                if (flit_count != CNT_W'(1)) state_next = S_HEAD_LOAD;
                if (ret_delay != '0 && ret_count != CNT_W'(DEPTH)) begin
                  ret_req.we     = 1'b1;
                  ret_req.waddr  = ptr_add(ret_head, ret_count);
                  ret_req.wdata  = ret_time_new;
                  ret_count_next = ret_count + 1'b1;
                  if (ret_count == '0) ret_head_time_next = ret_time_new;
                end else if (used_credits != '0) begin
                  used_credits_next = used_credits - 1'b1;
                end
              end
            end
            CMD_TAKE_CREDIT: begin
              if (used_credits != CNT_W'(DEPTH)) used_credits_next = used_credits + 1'b1;
            end
            CMD_CLEAR: begin
              head_ptr_next     = '0;
              tail_ptr_next     = '0;
              flit_count_next   = '0;
              used_credits_next = '0;
              ret_head_next     = '0;
              ret_count_next    = '0;
            end
            default: ;
          endcase
        end
      end
      S_HEAD_LOAD: begin
        head_flit_next = flit_rdata;
        state_next     = S_RET_CHECK;
      end
      S_RET_CHECK: begin
        if (ret_due) begin
          ret_head_next  = ptr_wrap(ret_head);
          ret_count_next = ret_count - 1'b1;
          if (used_credits != '0) used_credits_next = used_credits - 1'b1;
          ret_req.raddr  = ptr_wrap(ret_head);
          if (ret_count != CNT_W'(1)) state_next = S_RET_WAIT;
        end else if (!res_valid || res_ready) begin
          res_load       = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RET_WAIT: begin
        ret_head_time_next = ret_rdata;
        state_next         = S_RET_CHECK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      flit_count   <= '0;
      used_credits <= '0;
      cur_time     <= '0;
      ret_head     <= '0;
      ret_count    <= '0;
      res_valid    <= 1'b0;
      ret_delay    <= '0;
      depth_in_use <= DIU_W'(16);
    end else begin
      state        <= state_next;
      head_ptr     <= head_ptr_next;
      tail_ptr     <= tail_ptr_next;
      flit_count   <= flit_count_next;
      used_credits <= used_credits_next;
      cur_time     <= cur_time_next;
      ret_head     <= ret_head_next;
      ret_count    <= ret_count_next;
      res_valid    <= res_valid_next;
      if (wr_en) begin
        unique case (reg_idx_t'(wr_index))
          REG_RET_DELAY:    ret_delay    <= wr_data[DELAY_W-1:0];
          REG_DEPTH_IN_USE: depth_in_use <= wr_data[DIU_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    head_flit     <= head_flit_next;
    tail_flit     <= tail_flit_next;
    ret_head_time <= ret_head_time_next;
    op_flit       <= op_flit_next;
    op_status     <= op_status_next;
    if (res_load) begin
      res_out_flit  <= op_flit;
      res_head_flit <= (flit_count != '0) ? head_flit : '0;
      res_tail_flit <= (flit_count != '0) ? tail_flit : '0;
      res_occupancy <= OCC_W'(flit_count);
      res_full      <= (used_credits >= eff);
      res_status    <= op_status;
    end
  end

endmodule

>>> rtl/core/vfb_checker.sv
// Port-level assertions for the flit buffer, bound to the top level.
module vfb_checker import vfb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [FLIT_W-1:0] head_flit,
  input logic [FLIT_W-1:0] tail_flit,
  input logic [OCC_W-1:0]  occupancy,
  input logic [STAT_W-1:0] status
);

  // one word in flight: no second accept right after the first
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted back to back");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && occupancy == '0) |-> (head_flit == '0 && tail_flit == '0))
    else $error("empty buffer reports nonzero head or tail");

  // a refused enqueue needs at least one flit held
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_FULL) |-> (occupancy != '0))
    else $error("enqueue refused with empty buffer");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
    else $error("bad status code");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(status) && $stable(occupancy)))
    else $error("stalled result changed");

endmodule

bind vc_flit_buffer_delayed_credits vfb_checker u_vfb_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_ch.valid),
  .cmd_ready (cmd_ch.ready),
  .res_valid (res_ch.valid),
  .res_ready (res_ch.ready),
  .head_flit (res_ch.head_flit),
  .tail_flit (res_ch.tail_flit),
  .occupancy (res_ch.occupancy),
  .status    (res_ch.status)
);
